[hw/rtl/buffer_slot_free_list_defines.svh]
// Assertion macros shared by the buffer slot free list RTL.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef BUFFER_SLOT_FREE_LIST_DEFINES_SVH
`define BUFFER_SLOT_FREE_LIST_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BFL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BFL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/bfl_pkg.sv]
// Package for the buffer slot free list: mode codes, controller states and
// the command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bfl_pkg;

  localparam logic [1:0] MODE_GET      = 2'd0;
  localparam logic [1:0] MODE_RELEASE  = 2'd1;
  localparam logic [1:0] MODE_OPTIMIZE = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_OPT_RD,
    ST_OPT_CMP
  } bfl_state_t;

  typedef struct packed {
    logic latch_in;
    logic clr_wr;
    logic exec;
    logic opt_rd;
    logic opt_wr;
    logic opt_finish;
  } bfl_cmd_t;

  typedef struct packed {
    logic idx_last;
    logic walk_opt;
    logic idx_below;
    logic opt_stop;
  } bfl_stat_t;

endpackage

`default_nettype wire

[hw/rtl/bfl_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bfl_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[hw/rtl/bfl_ctrl.sv]
// Controller state machine of the buffer slot free list.
// Uses bfl_pkg; drives datapath commands and the channel handshakes.
`timescale 1ns / 1ps
`default_nettype none

module bfl_ctrl import bfl_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire bfl_stat_t stat,
  output bfl_cmd_t       cmd
);

  bfl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.idx_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // The result goes straight into the output register, so wait for it.
        if (out_free) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = stat.walk_opt ? ST_OPT_RD : ST_IDLE;
        end
      end
      ST_OPT_RD: begin
        // Links below the highest used slot are rewritten without a look.
        if (stat.idx_below) begin
          cmd.opt_wr = 1'b1;
        end else begin
          cmd.opt_rd = 1'b1;
          state_nxt  = ST_OPT_CMP;
        end
      end
      ST_OPT_CMP: begin
        if (stat.opt_stop) begin
          cmd.opt_finish = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          cmd.opt_wr = 1'b1;
          if (stat.idx_last) begin
            cmd.opt_finish = 1'b1;
            state_nxt      = ST_IDLE;
          end else begin
            state_nxt = ST_OPT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[hw/rtl/bfl_dp.sv]
// Datapath of the buffer slot free list: link table, head, highest-used record,
// walk index and output payload. Uses bfl_pkg and bfl_ram.
`timescale 1ns / 1ps
`default_nettype none

module bfl_dp import bfl_pkg::*; #(
  parameter int NUM_SLOTS = 1024,
  localparam int SLOT_W = $clog2(NUM_SLOTS + 1),
  localparam int ADDR_W = $clog2(NUM_SLOTS)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bfl_cmd_t          cmd,
  output bfl_stat_t              stat,
  input  wire logic [1:0]        in_mode,
  input  wire logic [SLOT_W-1:0] in_slot,
  output logic      [SLOT_W-1:0] out_granted_slot,
  output logic                   out_exhausted
);

  localparam logic [SLOT_W-1:0] NONE_S   = SLOT_W'(NUM_SLOTS);
  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(NUM_SLOTS - 1);

  logic [1:0]        mode_r, mode_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [ADDR_W-1:0] hu_r, hu_nxt;
  logic              hv_r, hv_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [SLOT_W-1:0] gs_r, gs_nxt;
  logic              ex_r, ex_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [SLOT_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [SLOT_W-1:0] ram_rdata;

  logic [SLOT_W-1:0] want;
  logic [ADDR_W-1:0] got;
  logic              head_ok;
  logic              slot_ok;

  bfl_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (NUM_SLOTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Sequential link of an in-range slot is always slot + 1 (the last one
  // then points to the none code).
  assign want    = SLOT_W'(idx_r) + SLOT_W'(1);
  assign got     = head_r[ADDR_W-1:0];
  assign head_ok = head_r < NONE_S;
  assign slot_ok = slot_r < NONE_S;

  assign stat.idx_last  = idx_r == LAST_IDX;
  assign stat.walk_opt  = (mode_r == MODE_OPTIMIZE) && hv_r;
  assign stat.idx_below = idx_r < hu_r;
  assign stat.opt_stop  = !stat.idx_below && (ram_rdata == want);

  always_comb begin
    mode_nxt  = mode_r;
    slot_nxt  = slot_r;
    head_nxt  = head_r;
    hu_nxt    = hu_r;
    hv_nxt    = hv_r;
    idx_nxt   = idx_r;
    gs_nxt    = gs_r;
    ex_nxt    = ex_r;
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = want;
    // The head entry is read whenever no walk needs the port, so a get
    // finds its successor already read when it executes.
    ram_raddr = cmd.opt_rd ? idx_r : got;

    if (cmd.latch_in) begin
      mode_nxt = in_mode;
      slot_nxt = in_slot;
    end

    if (cmd.clr_wr || cmd.opt_wr) begin
      ram_we  = 1'b1;
      idx_nxt = stat.idx_last ? '0 : idx_r + ADDR_W'(1);
    end

    if (cmd.exec) begin
      gs_nxt = '0;
      ex_nxt = 1'b0;
      case (mode_r)
        MODE_GET: begin
          if (head_ok) begin
            head_nxt = ram_rdata;
            gs_nxt   = head_r;
            if (!hv_r || (got > hu_r)) begin
              hu_nxt = got;
              hv_nxt = 1'b1;
            end
          end else begin
            gs_nxt = NONE_S;
            ex_nxt = 1'b1;
          end
        end
        MODE_RELEASE: begin
          if (slot_ok) begin
            ram_we    = 1'b1;
            ram_waddr = slot_r[ADDR_W-1:0];
            ram_wdata = head_r;
            head_nxt  = slot_r;
          end
        end
        MODE_OPTIMIZE: begin
          idx_nxt = '0;
        end
        default: begin
          gs_nxt = '0;
        end
      endcase
    end

    if (cmd.opt_finish) begin
      hu_nxt   = '0;
      hv_nxt   = 1'b0;
      head_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      hu_r   <= '0;
      hv_r   <= 1'b0;
      idx_r  <= '0;
    end else begin
      head_r <= head_nxt;
      hu_r   <= hu_nxt;
      hv_r   <= hv_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    slot_r <= slot_nxt;
    gs_r   <= gs_nxt;
    ex_r   <= ex_nxt;
  end

  assign out_granted_slot = gs_r;
  assign out_exhausted    = ex_r;

endmodule

`default_nettype wire

[hw/rtl/buffer_slot_free_list.sv]
// Top level of the buffer slot free list allocator.
// Uses bfl_pkg, bfl_ctrl, bfl_dp (with bfl_ram) and the assertion macro header.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid / in_ready    in_mode, in_slot
//   out      output     out_valid / out_ready  out_granted_slot, out_exhausted
//
// After reset the link table is filled with sequential links, one entry per
// cycle, so no item is taken until the fill is done.
// A get or a release is taken in the idle state, where the head entry of the
// table is read, and head and table are updated in the execute state.
// An optimize after a grant also walks the table: the read state rewrites
// each slot below the highest used slot, then the read and compare states
// read, compare and write each slot until a link already matches or the table ends.
// The result goes straight into the output register; an item waits in its
// execute state while the previous result has not been taken, and the next item
// is taken while a result sits in the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "buffer_slot_free_list_defines.svh"

module buffer_slot_free_list import bfl_pkg::*; #(
  parameter int NUM_SLOTS = 1024,
  localparam int SLOT_W = $clog2(NUM_SLOTS + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_mode,
  input  wire logic [SLOT_W-1:0] in_slot,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [SLOT_W-1:0] out_granted_slot,
  output logic                   out_exhausted
);

  bfl_cmd_t  cmd;
  bfl_stat_t stat;

  // The controller sequences every item; it sees the datapath only through
  // the command and status structs.
  bfl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the link table, the list head and the record of the
  // highest slot handed out, and it forms the result payload.
  bfl_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_mode          (in_mode),
    .in_slot          (in_slot),
    .out_granted_slot (out_granted_slot),
    .out_exhausted    (out_exhausted)
  );

  // One item at a time: after an item is taken the block is busy in its execute state.
  `BFL_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "item taken while busy")
  // No item may be taken while the table is being filled after reset.
  `BFL_ASSERT_SAME(a_no_take_in_fill, cmd.clr_wr, !in_ready, "item taken during table fill")
  // An exhausted result always carries the error slot.
  `BFL_ASSERT_SAME(a_exh_slot, out_valid && out_exhausted,
                   out_granted_slot == SLOT_W'(NUM_SLOTS), "exhausted without error slot")
  // A granted slot never lies above the error slot.
  `BFL_ASSERT_SAME(a_slot_range, out_valid, out_granted_slot <= SLOT_W'(NUM_SLOTS),
                   "granted slot out of range")
  // A result is only loaded when the output register is free or being emptied.
  `BFL_ASSERT_SAME(a_load_free, cmd.exec, !out_valid || out_ready,
                   "result loaded over a waiting result")

endmodule

`default_nettype wire

[bench/free_list_check_pkg.sv]
// Scoreboard for the buffer slot free list bench: a model of the link table and
// head register, plus the queue of awaited results. Depends on bfl_pkg.
`timescale 1ns / 1ps

package free_list_check_pkg;
  import bfl_pkg::*;

  localparam int FL_SLOTS = 1024;
  localparam int FL_SLOT_W = $clog2(FL_SLOTS + 1);
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int REPORT_LIMIT = 10;

  typedef logic [FL_SLOT_W-1:0] slot_t;

  typedef struct packed {
    slot_t granted;
    logic  exhausted;
  } grant_t;

  class grant_tracker;
    slot_t link_table [FL_SLOTS];
    slot_t list_head;
    slot_t top_slot;
    bit top_valid;
    grant_t awaited [$];
    int failures;
    int checked;
    int n_get;
    int n_exhausted;
    int n_release;
    int n_optimize;
    int n_ignored;

    function new();
      int i;
      for (i = 0; i < FL_SLOTS; i++) link_table[i] = seq_link(i);
      list_head = '0;
      top_slot = '0;
      top_valid = 1'b0;
      failures = 0;
      checked = 0;
      n_get = 0;
      n_exhausted = 0;
      n_release = 0;
      n_optimize = 0;
      n_ignored = 0;
    endfunction

    function slot_t seq_link(int i);
      return (i + 1 < FL_SLOTS) ? slot_t'(i + 1) : slot_t'(FL_SLOTS);
    endfunction

    // Relink into sequential order, stopping once at or past the highest slot
    // handed out and the link already matches.
    function void relink();
      int i;
      slot_t want;
      bit reached;
      if (!top_valid) return;
      reached = 1'b0;
      for (i = 0; i < FL_SLOTS; i++) begin
        want = seq_link(i);
        if (slot_t'(i) == top_slot) reached = 1'b1;
        if (reached && link_table[i] == want) break;
        link_table[i] = want;
      end
      top_slot = '0;
      top_valid = 1'b0;
      list_head = '0;
    endfunction

    function grant_t apply_item(logic [1:0] mode, slot_t slot);
      grant_t r;
      slot_t got;
      r.granted = '0;
      r.exhausted = 1'b0;
      case (mode)
        MODE_GET: begin
          n_get++;
          if (list_head >= FL_SLOTS) begin
            r.granted = slot_t'(FL_SLOTS);
            r.exhausted = 1'b1;
            n_exhausted++;
          end else begin
            got = list_head;
            list_head = link_table[got];
            if (!top_valid || got > top_slot) begin
              top_slot = got;
              top_valid = 1'b1;
            end
            r.granted = got;
          end
        end
        MODE_RELEASE: begin
          if (slot < FL_SLOTS) begin
            n_release++;
            link_table[slot] = list_head;
            list_head = slot;
          end else begin
            n_ignored++;
          end
        end
        MODE_OPTIMIZE: begin
          n_optimize++;
          relink();
        end
        default: n_ignored++;
      endcase
      awaited = {awaited, r};
      return r;
    endfunction

    function void note_failure(string msg);
      if (failures < REPORT_LIMIT) $display("MISMATCH: %s", msg);
      failures++;
    endfunction

    function void check_grant(slot_t granted, logic exhausted);
      grant_t want;
      if (awaited.size() == 0) begin
        note_failure($sformatf("result slot %0d exhausted %0b with no item outstanding",
                               granted, exhausted));
        return;
      end
      want = awaited.pop_front();
      if (granted !== want.granted)
        note_failure($sformatf("result %0d granted_slot expected %0d actual %0d",
                               checked, want.granted, granted));
      if (exhausted !== want.exhausted)
        note_failure($sformatf("result %0d exhausted expected %0b actual %0b",
                               checked, want.exhausted, exhausted));
      checked++;
    endfunction
  endclass

endpackage

[bench/testbench.sv]
// Top of the buffer slot free list bench: clock, reset, item drivers and the
// stimulus. Depends on bfl_pkg, free_list_check_pkg and the buffer_slot_free_list RTL.
`timescale 1ns / 1ps

module testbench;
  import bfl_pkg::*;
  import free_list_check_pkg::*;

  // The longest quiet stretch of a correct run is the table clearing pass after
  // reset, or an optimize that walks the whole table.
  // Both stay well under this many cycles without any handshake.
  localparam int IDLE_LIMIT = 20000;
  // Draining the whole list already takes over a thousand items, so the
  // random part is kept short.
  localparam int RANDOM_ITEMS = 80;
  localparam int DRAIN_EXTRA = 3;
  localparam int END_CYCLES = 20;
  localparam int SLOT_FIELD_MAX = (1 << FL_SLOT_W) - 1;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_mode = MODE_GET;
  slot_t      in_slot = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  slot_t      out_granted_slot;
  logic       out_exhausted;

  grant_tracker tracker;

  // Slots the bench believes it holds; released items are drawn from here so
  // that most releases hand back a slot that was really granted.
  slot_t held [$];

  // While set, the matching side runs without idle cycles.
  bit in_steady = 1'b0;
  bit out_steady = 1'b0;

  // Items that change or query the list; ignored items are left out.
  int effective_items = 0;

  buffer_slot_free_list #(.NUM_SLOTS(FL_SLOTS)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_slot          (in_slot),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_granted_slot (out_granted_slot),
    .out_exhausted    (out_exhausted)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Drive one item. Inputs change only at the falling edge and the handshake
  // is sampled at the rising edge. With no gap, valid stays high and only the
  // payload changes, so valid gets one assignment per falling edge. The
  // expected result is computed the moment the item is accepted.
  task automatic send_item(input logic [1:0] mode, input slot_t slot, output grant_t r);
    int gap;
    gap = in_steady ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_mode <= mode;
    in_slot <= slot;
    do @(posedge clk); while (in_ready !== 1'b1);
    r = tracker.apply_item(mode, slot);
    if (mode != MODE_UNUSED && !(mode == MODE_RELEASE && slot >= FL_SLOTS))
      effective_items++;
  endtask

  // A get carries a random slot field, which the block does not look at.
  task automatic get_slot();
    grant_t r;
    send_item(MODE_GET, slot_t'($urandom_range(0, SLOT_FIELD_MAX)), r);
    if (!r.exhausted) held = {held, r.granted};
  endtask

  task automatic release_slot(input slot_t slot);
    grant_t r;
    send_item(MODE_RELEASE, slot, r);
  endtask

  // Hand back a randomly chosen held slot, so release order differs from
  // grant order.
  task automatic release_held();
    int idx;
    slot_t s;
    if (held.size() == 0) return;
    idx = $urandom_range(0, held.size() - 1);
    s = held[idx];
    held.delete(idx);
    release_slot(s);
  endtask

  // After an optimize every slot counts as free again, held or not.
  task automatic optimize();
    grant_t r;
    send_item(MODE_OPTIMIZE, slot_t'($urandom_range(0, SLOT_FIELD_MAX)), r);
    held.delete();
  endtask

  // Items outside the normal allocate and release pattern: the unused mode,
  // releases of the error slot or beyond, releases of random in-range slots
  // that may already be free, and stray gets.
  task automatic noise_item();
    grant_t r;
    case ($urandom_range(0, 3))
      0: send_item(MODE_UNUSED, slot_t'($urandom_range(0, SLOT_FIELD_MAX)), r);
      1: release_slot(slot_t'($urandom_range(FL_SLOTS, SLOT_FIELD_MAX)));
      2: release_slot(slot_t'($urandom_range(0, FL_SLOTS - 1)));
      default: get_slot();
    endcase
  endtask

  // Result side: the ready line idles between results, with occasional long
  // stretches where it stays high.
  initial begin : result_sink
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0) out_steady = !out_steady;
      stall = out_steady ? 0 : $urandom_range(0, 4);
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      tracker.check_grant(out_granted_slot, out_exhausted);
    end
  end

  // The run ends with a failure if no item moves on either channel for too
  // long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Watchdog: no item accepted for %0d cycles.", IDLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    grant_t r;
    int kind;
    int n;
    int rand_start;
    tracker = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. An optimize straight after reset has no slot recorded
    // and must leave everything alone.
    optimize();
    get_slot();
    get_slot();
    get_slot();
    release_held();
    release_held();
    release_held();
    // Slot 0 is free already, so this is a double release; the list then
    // holds slot 0 twice.
    release_slot('0);
    // The error slot and a slot far out of range are both ignored.
    release_slot(slot_t'(FL_SLOTS));
    release_slot(slot_t'(SLOT_FIELD_MAX));
    send_item(MODE_UNUSED, slot_t'(SLOT_FIELD_MAX), r);
    send_item(MODE_UNUSED, '0, r);
    get_slot();
    get_slot();
    // Optimize while slots are still out.
    optimize();
    // Pushing the last slot breaks its link to the end of the list; a grant
    // of it records the highest slot, so the next optimize walks the whole
    // table and repairs the last link.
    release_slot(slot_t'(FL_SLOTS - 1));
    get_slot();
    get_slot();
    optimize();
    get_slot();
    release_held();
    optimize();

    // Drain the whole list: gets until one answers with the error slot, a
    // few more while empty, then hand some back and restore the order.
    r.exhausted = 1'b0;
    while (!r.exhausted) begin
      if ($urandom_range(0, 49) == 0) in_steady = !in_steady;
      send_item(MODE_GET, slot_t'($urandom_range(0, SLOT_FIELD_MAX)), r);
      if (!r.exhausted) held = {held, r.granted};
    end
    repeat (DRAIN_EXTRA) get_slot();
    repeat (8) release_held();
    repeat (2) get_slot();
    optimize();

    // Random part. Most of it is allocate and release traffic with random
    // sizes and order, with optimizes in between; the rest is noise.
    rand_start = effective_items;
    while (effective_items - rand_start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) in_steady = !in_steady;
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
        repeat (n) get_slot();
        if ($urandom_range(0, 9) < 7) begin
          while (held.size() != 0) release_held();
          if ($urandom_range(0, 1) == 1) optimize();
        end
      end else if (kind < 55) begin
        repeat ($urandom_range(1, 8)) release_held();
      end else if (kind < 65) begin
        optimize();
      end else if (kind < 85) begin
        repeat ($urandom_range(2, 12)) begin
          if ($urandom_range(0, 1) == 1) get_slot();
          else release_held();
        end
      end else begin
        repeat ($urandom_range(1, 4)) noise_item();
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;

    // Wait for every awaited result, then a short quiet stretch to catch any
    // result the block should not have produced.
    while (tracker.awaited.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);

    $display("Run covered %0d gets (%0d found the list empty), %0d releases, %0d optimizes",
             tracker.n_get, tracker.n_exhausted, tracker.n_release, tracker.n_optimize);
    $display("and %0d ignored items; %0d results checked, %0d failures.",
             tracker.n_ignored, tracker.checked, tracker.failures);
    if (tracker.failures == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
